>>> rtl/ostb_pkg.sv
// ----------------------------------------------------------------------------
// One-shot timer bank package
// Shared sizes, request codes and the layout of one timer entry in state RAM.
// ----------------------------------------------------------------------------
package ostb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int TIMER_IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   localparam int KIND_W  = 2;
   localparam int ID_W    = 3;
   localparam int COUNT_W = 31;
   localparam int TAG_W   = 32;

   // Request tdata: timer_id, deliver_mode, tick_count, handler_tag, padded to bytes.
   localparam int REQ_FIELDS_W = ID_W + 1 + COUNT_W + TAG_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Response tdata: expired_id, expired_mode, expired_tag, padded to bytes.
   localparam int RSP_FIELDS_W = ID_W + 1 + TAG_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   // One timer entry as held in the state RAM.
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> rtl/ostb_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ostb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/one_shot_timer_bank.sv
// ----------------------------------------------------------------------------
// One-shot timer bank
// A bank of TIMER_COUNT one-shot down-counting timers with expiry reporting.
// ----------------------------------------------------------------------------
// Each request transfer carries a kind in req_tuser: a start arms one timer
// with a tick count, a delivery mode and a handler tag (a count of zero
// expires on the next tick, like a count of one); a stop disarms one timer;
// a tick counts down every armed timer. Starts and stops with an index past
// the bank, and the unused kind code, are ignored. For every timer that
// expires on a tick, one response transfer carries its index, mode and tag,
// in ascending index order, with tlast on the final one of that tick; a tick
// with no expiry produces no response. Counts and tags live in a small state
// RAM; armed and mode bits live in flip-flops. A start or stop is applied in
// the cycle it is accepted. A tick runs in steps: the accepting cycle, then
// a walk over every timer as the sequencer steps through the single RAM read
// port, with the next read issued while the current entry is evaluated, then
// a flush step to release the last held result, which is spent even when
// nothing expired. A stalled response channel holds the walk when a second
// expiry needs the output register while it is still full, and holds the end
// of the tick until the output register can take the last result.
// ----------------------------------------------------------------------------
module one_shot_timer_bank (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata, low bit up: timer_id[2:0], deliver_mode, tick_count[30:0],
   // handler_tag[31:0], zero pad.
   input  logic [ostb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: kind[1:0].
   input  logic [ostb_pkg::KIND_W-1:0]       req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata, low bit up: expired_id[2:0], expired_mode, expired_tag[31:0],
   // zero pad.
   output logic [ostb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tlast: last_of_tick.
   output logic                              rsp_tlast
);

   import ostb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   // Control state.
   state_type                state_ff, state_in;
   logic [TIMER_IDX_W-1:0]   idx_ff, idx_in;
   logic [TIMER_COUNT-1:0]   armed_ff, armed_in;
   logic [TIMER_COUNT-1:0]   mode_ff, mode_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Held expiry, waiting to learn whether it is the last of the tick.
   logic [ID_W-1:0]          pend_id_ff, pend_id_in;
   logic                     pend_mode_ff, pend_mode_in;
   logic [TAG_W-1:0]         pend_tag_ff, pend_tag_in;

   // Output register payload.
   logic [ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic                     rsp_mode_ff, rsp_mode_in;
   logic [TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;
   logic                     rsp_last_ff, rsp_last_in;

   // State RAM ports.
   logic                     ram_we;
   logic [TIMER_IDX_W-1:0]   ram_waddr;
   entry_type                ram_wdata;
   logic [TIMER_IDX_W-1:0]   ram_raddr;
   entry_type                ram_rdata;

   // Request fields.
   logic [ID_W-1:0]          req_id;
   logic                     req_mode;
   logic [COUNT_W-1:0]       req_count;
   logic [TAG_W-1:0]         req_tag;
   logic                     req_id_ok;
   logic [TIMER_IDX_W-1:0]   req_addr;
   logic                     req_accept;

   // Walk datapath.
   logic                     cur_armed;
   logic                     cur_expire;
   logic                     cur_last;
   logic                     out_free;
   logic                     walk_stall;
   logic                     push;
   logic                     push_last;

   assign req_id    = req_tdata[ID_W-1:0];
   assign req_mode  = req_tdata[ID_W];
   assign req_count = req_tdata[ID_W+1 +: COUNT_W];
   assign req_tag   = req_tdata[ID_W+1+COUNT_W +: TAG_W];
   assign req_id_ok = 6'(req_id) < 6'(TIMER_COUNT);
   assign req_addr  = TIMER_IDX_W'(req_id);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // A count of zero or one expires on this tick; the RAM data belongs to idx_ff.
   assign cur_armed  = armed_ff[idx_ff];
   assign cur_expire = cur_armed && (ram_rdata.count <= COUNT_W'(1));
   assign cur_last   = (idx_ff == TIMER_IDX_W'(TIMER_COUNT - 1));

   // The output register can take a new result when empty or draining now.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign walk_stall = cur_expire && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      armed_in      = armed_ff;
      mode_in       = mode_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_mode_in  = pend_mode_ff;
      pend_tag_in   = pend_tag_ff;

      ram_we        = 1'b0;
      ram_waddr     = req_addr;
      ram_wdata     = '{tag: req_tag, count: req_count};
      ram_raddr     = '0;

      push          = 1'b0;
      push_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Entry zero is read every idle cycle, so a tick finds it ready.
            if (req_accept) begin
               case (req_tuser)
                  KIND_TICK: begin
                     state_in = ST_WALK;
                     idx_in   = '0;
                  end
                  KIND_START: begin
                     if (req_id_ok) begin
                        ram_we             = 1'b1;
                        armed_in[req_addr] = 1'b1;
                        mode_in[req_addr]  = req_mode;
                     end
                  end
                  KIND_STOP: begin
                     if (req_id_ok) begin
                        armed_in[req_addr] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (walk_stall) begin
               // Re-read the same entry so its data is still there next cycle.
               ram_raddr = idx_ff;
            end else begin
               ram_raddr = cur_last ? '0 : idx_ff + TIMER_IDX_W'(1);
               idx_in    = cur_last ? '0 : idx_ff + TIMER_IDX_W'(1);
               state_in  = cur_last ? ST_FLUSH : ST_WALK;
               if (cur_armed && !cur_expire) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = '{tag: ram_rdata.tag, count: ram_rdata.count - COUNT_W'(1)};
               end
               if (cur_expire) begin
                  armed_in[idx_ff] = 1'b0;
                  if (pend_valid_ff) begin
                     push = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = ID_W'(idx_ff);
                  pend_mode_in  = mode_ff[idx_ff];
                  pend_tag_in   = ram_rdata.tag;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on push, otherwise hold until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = pend_id_ff;
         rsp_mode_in  = pend_mode_ff;
         rsp_tag_in   = pend_tag_ff;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         armed_ff      <= '0;
         mode_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         armed_ff      <= armed_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff   <= pend_id_in;
      pend_mode_ff <= pend_mode_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   ostb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TIMER_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_tag_ff, rsp_mode_ff, rsp_id_ff});

`ifndef NO_ASSERTIONS
   // No expiry may be left behind when the bank goes back to taking requests.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_valid_ff && (idx_ff == '0)))
      else $error("held expiry or walk index left over in idle");

   // An expiring timer is disarmed once the walk moves past it.
   a_expire_disarms: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && cur_expire && !walk_stall) |=> !armed_ff[$past(idx_ff)])
      else $error("expired timer still armed");

   // A result that is not the last of its tick comes only from the walk.
   a_mid_push_in_walk: assert property (@(posedge clock) disable iff (reset)
      (push && !push_last) |-> (state_ff == ST_WALK))
      else $error("non-final result pushed outside the walk");

   // The output register is never overwritten while a result waits in it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("output register overwritten");
`endif

endmodule
